// ===== sv/poeh_pkg.sv =====
// Shared types, constants and helper functions for the pot oversampling filter.
// Depends on nothing; every other file in the block imports this package.
package poeh_pkg;

  localparam int unsigned NUM_POTS_DEF = 5;
  localparam int unsigned MAP_LEN      = 5;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned POT_W    = 3;
  localparam int unsigned SUM_W    = 18;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned ALPHA_W  = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [SAMPLE_W-1:0] ADC_MAX    = 12'd4095;
  localparam logic [CNT_W-1:0]    MAX_WINDOW = 7'd64;

  localparam logic [CNT_W-1:0]    OVERSAMPLE_RST = 7'd8;
  localparam logic [ALPHA_W-1:0]  ALPHA_RST      = 16'd16384;
  localparam logic [SAMPLE_W-1:0] HYST_BASE_RST  = 12'd8;
  localparam logic [GAIN_W-1:0]   HYST_GAIN_RST  = 16'd3277;

  // Converter channels that carry pots, in pot order.
  localparam logic [CHAN_W-1:0] CHAN_POT0 = 4'd0;
  localparam logic [CHAN_W-1:0] CHAN_POT1 = 4'd1;
  localparam logic [CHAN_W-1:0] CHAN_POT2 = 4'd3;
  localparam logic [CHAN_W-1:0] CHAN_POT3 = 4'd4;
  localparam logic [CHAN_W-1:0] CHAN_POT4 = 4'd5;

  localparam logic [CHAN_W-1:0] CHAN_MAP [MAP_LEN] = '{
    CHAN_POT0, CHAN_POT1, CHAN_POT2, CHAN_POT3, CHAN_POT4
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVERSAMPLE = 4'd0,
    REG_EMA_ALPHA  = 4'd1,
    REG_HYST_BASE  = 4'd2,
    REG_HYST_GAIN  = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAN_W-1:0]   adc_channel;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [POT_W-1:0]    pot_index;
    logic [SAMPLE_W-1:0] filtered;
    logic [SAMPLE_W-1:0] stable;
    logic                stable_changed;
  } out_item_t;

  // Completed window handed from the front to the back.
  typedef struct packed {
    logic [POT_W-1:0] pot;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic [ALPHA_W-1:0]  ema_alpha;
    logic [SAMPLE_W-1:0] hyst_base;
    logic [GAIN_W-1:0]   hyst_gain;
  } filt_cfg_t;

  typedef struct packed {
    logic             hit;
    logic [POT_W-1:0] pot;
  } pot_map_t;

  function automatic pot_map_t map_channel(logic [CHAN_W-1:0] ch);
    pot_map_t m;
    m.hit = 1'b0;
    m.pot = '0;
    for (int i = MAP_LEN - 1; i >= 0; i--) begin
      if (CHAN_MAP[i] == ch) begin
        m.hit = 1'b1;
        m.pot = POT_W'(i);
      end
    end
    return m;
  endfunction

endpackage

// ===== sv/poeh_queue.sv =====
// Small register queue carrying completed windows from the front to the back.
// Depends on poeh_pkg for the job type.
module poeh_queue import poeh_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  job_t push_data_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output job_t pop_data_o,
  input  logic pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/poeh_front.sv =====
// Front end: maps converter channels to pots and accumulates window sums.
// Depends on poeh_pkg; hands each completed window to the queue.
module poeh_front import poeh_pkg::*; #(
  parameter int unsigned NUM_POTS = NUM_POTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] win_len_i,
  input  logic             in_valid_i,
  input  in_item_t         in_data_i,
  output logic             in_ready_o,
  output logic             push_valid_o,
  output job_t             push_data_o,
  input  logic             push_ready_i
);

  localparam int unsigned PotW = (NUM_POTS > 1) ? $clog2(NUM_POTS) : 1;

  logic [SUM_W-1:0] sum_q [NUM_POTS];
  logic [CNT_W-1:0] cnt_q [NUM_POTS];

  pot_map_t         map;
  logic             hit, fire, done;
  logic [PotW-1:0]  idx;
  logic [SUM_W-1:0] sum_d;
  logic [CNT_W-1:0] cnt_d;

  assign map   = map_channel(in_data_i.adc_channel);
  assign hit   = map.hit && (32'(map.pot) < NUM_POTS);
  assign idx   = PotW'(map.pot);
  assign sum_d = sum_q[idx] + SUM_W'(in_data_i.sample);
  assign cnt_d = cnt_q[idx] + 1'b1;
  assign done  = (cnt_d >= win_len_i);

  // A transfer is taken only while the queue has room for a possible window.
  assign in_ready_o = push_ready_i;
  assign fire       = in_valid_i && in_ready_o && hit;

  assign push_valid_o      = fire && done;
  assign push_data_o.pot   = map.pot;
  assign push_data_o.sum   = sum_d;
  assign push_data_o.count = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_POTS; i++) begin
        sum_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else if (fire) begin
      sum_q[idx] <= done ? '0 : sum_d;
      cnt_q[idx] <= done ? '0 : cnt_d;
    end
  end

endmodule

// ===== sv/poeh_back.sv =====
// Back end: divides the window sum, runs the EMA and the adaptive hysteresis.
// Depends on poeh_pkg; holds per-pot filter and stable values and the result register.
module poeh_back import poeh_pkg::*; #(
  parameter int unsigned NUM_POTS = NUM_POTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  filt_cfg_t cfg_i,
  input  logic      pop_valid_i,
  input  job_t      pop_data_i,
  output logic      pop_ready_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_ready_i
);

  localparam int unsigned PotW  = (NUM_POTS > 1) ? $clog2(NUM_POTS) : 1;
  localparam int unsigned StepW = $clog2(SUM_W);
  localparam int unsigned PrdW  = SAMPLE_W + 1 + ALPHA_W + 1;
  localparam int unsigned HPrdW = SAMPLE_W + GAIN_W;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DIV      = 6'b000010,
    S_EMA_MUL  = 6'b000100,
    S_EMA_ADD  = 6'b001000,
    S_HYST_MUL = 6'b010000,
    S_HYST_CMP = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [SAMPLE_W-1:0] filt_q [NUM_POTS];
  logic [SAMPLE_W-1:0] stab_q [NUM_POTS];

  logic [POT_W-1:0]        pot_q;
  logic [SUM_W-1:0]        quo_q;
  logic [CNT_W-1:0]        rem_q, div_q;
  logic [StepW-1:0]        step_q;
  logic signed [PrdW-1:0]  prod_q;
  logic [SAMPLE_W-1:0]     f_q, mag_q;
  logic [HPrdW-1:0]        hprod_q;
  logic                    out_valid_q;
  out_item_t               out_q;

  logic [PotW-1:0]           idx;
  logic [CNT_W:0]            trial, diff;
  logic                      ge;
  logic [SAMPLE_W-1:0]       avg, y, s, f_new, mag;
  logic signed [SAMPLE_W:0]  d;
  logic signed [ALPHA_W:0]   alpha_s;
  logic signed [SAMPLE_W+1:0] r;
  logic [SAMPLE_W:0]         adapt;
  logic                      changed, out_free;

  assign idx     = PotW'(pot_q);
  assign y       = filt_q[idx];
  assign s       = stab_q[idx];
  assign out_free = !out_valid_q || out_ready_i;

  // One quotient bit per cycle, restoring division.
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign ge    = (trial >= {1'b0, div_q});
  assign diff  = trial - {1'b0, div_q};

  assign avg     = (quo_q > SUM_W'(ADC_MAX)) ? ADC_MAX : quo_q[SAMPLE_W-1:0];
  assign d       = $signed({1'b0, avg}) - $signed({1'b0, y});
  assign alpha_s = $signed({1'b0, cfg_i.ema_alpha});

  // The upper product bits are the flooring shift by 16.
  assign r = $signed({2'b00, y}) + prod_q[PrdW-1:ALPHA_W];
  always_comb begin
    if (r < 0) begin
      f_new = '0;
    end else if (r > $signed({2'b00, ADC_MAX})) begin
      f_new = ADC_MAX;
    end else begin
      f_new = r[SAMPLE_W-1:0];
    end
  end

  assign mag     = (f_q > s) ? f_q - s : s - f_q;
  assign adapt   = {1'b0, cfg_i.hyst_base} + {1'b0, hprod_q[HPrdW-1:GAIN_W]};
  assign changed = ({1'b0, mag_q} > adapt);

  assign pop_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (pop_valid_i) state_d = S_DIV;
      S_DIV:      if (step_q == StepW'(SUM_W - 1)) state_d = S_EMA_MUL;
      S_EMA_MUL:  state_d = S_EMA_ADD;
      S_EMA_ADD:  state_d = S_HYST_MUL;
      S_HYST_MUL: state_d = S_HYST_CMP;
      S_HYST_CMP: if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_POTS; i++) begin
        filt_q[i] <= '0;
        stab_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_EMA_ADD) begin
        filt_q[idx] <= f_new;
      end
      if (state_q == S_HYST_CMP && out_free) begin
        out_valid_q <= 1'b1;
        if (changed) begin
          stab_q[idx] <= f_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        pot_q  <= pop_data_i.pot;
        quo_q  <= pop_data_i.sum;
        div_q  <= pop_data_i.count;
        rem_q  <= '0;
        step_q <= '0;
      end
      S_DIV: begin
        rem_q  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_q  <= {quo_q[SUM_W-2:0], ge};
        step_q <= step_q + 1'b1;
      end
      S_EMA_MUL:  prod_q <= d * alpha_s;
      S_EMA_ADD:  f_q <= f_new;
      S_HYST_MUL: begin
        mag_q   <= mag;
        hprod_q <= mag * cfg_i.hyst_gain;
      end
      S_HYST_CMP: begin
        if (out_free) begin
          out_q.pot_index      <= pot_q;
          out_q.filtered       <= f_q;
          out_q.stable         <= changed ? f_q : s;
          out_q.stable_changed <= changed;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/pot_oversample_ema_hysteresis.sv =====
// Top level of the pot oversampling filter: configuration registers and wiring.
// Depends on poeh_pkg, poeh_front, poeh_queue and poeh_back.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+-------------------------------------
//   in      | in_valid_i/in_ready_o  | in_data_i  (adc_channel, sample)
//   out     | out_valid_o/out_ready_i| out_data_o (pot_index, filtered, ...)
//   cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// The front takes one sample per cycle while the window queue has room.
// A completed window occupies the back while it is loaded, run through the
// bit-serial divider, then two EMA steps and two hysteresis steps. Its result
// is registered; the back takes no new window until then.
// Reset clears all window sums, counts, filter and stable values at once.
// A stalled output holds the back, which then fills the queue and stalls the input.
module pot_oversample_ema_hysteresis import poeh_pkg::*; #(
  parameter int unsigned NUM_POTS = NUM_POTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [CNT_W-1:0] oversample_q, win_len;
  filt_cfg_t        cfg_q;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  job_t             push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oversample_q    <= OVERSAMPLE_RST;
      cfg_q.ema_alpha <= ALPHA_RST;
      cfg_q.hyst_base <= HYST_BASE_RST;
      cfg_q.hyst_gain <= HYST_GAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_OVERSAMPLE: oversample_q    <= cfg_data_i[CNT_W-1:0];
        REG_EMA_ALPHA:  cfg_q.ema_alpha <= cfg_data_i[ALPHA_W-1:0];
        REG_HYST_BASE:  cfg_q.hyst_base <= cfg_data_i[SAMPLE_W-1:0];
        REG_HYST_GAIN:  cfg_q.hyst_gain <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero count acts as one; counts above the maximum saturate.
  always_comb begin
    if (oversample_q == '0) begin
      win_len = CNT_W'(1);
    end else if (oversample_q > MAX_WINDOW) begin
      win_len = MAX_WINDOW;
    end else begin
      win_len = oversample_q;
    end
  end

  poeh_front #(.NUM_POTS(NUM_POTS)) u_front (
    .clk_i,
    .rst_ni,
    .win_len_i    (win_len),
    .in_valid_i,
    .in_data_i,
    .in_ready_o,
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  poeh_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  poeh_back #(.NUM_POTS(NUM_POTS)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .out_valid_o,
    .out_data_o,
    .out_ready_i
  );

endmodule

// ===== sv/poeh_checker.sv =====
// Port-level checks for the pot oversampling filter, bound to the top level.
// Depends on poeh_pkg for the payload types.
module poeh_checker import poeh_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o,
  input logic      cfg_ready_o
);

  // A result that is not taken stays offered with the same payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transfer dropped or changed while stalled");

  // Only the five mapped pots can produce a result.
  a_pot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pot_index <= POT_W'(MAP_LEN - 1))
    else $error("result for a pot that no channel maps to");

  // A replaced stable value is the new filtered value.
  a_changed_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stable_changed |-> out_data_o.stable == out_data_o.filtered)
    else $error("stable value changed but differs from filtered value");

  // The configuration port never stalls.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind pot_oversample_ema_hysteresis poeh_checker u_poeh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);

// ===== bench/pot_oversample_ema_hysteresis_tb.sv =====
// Self-checking bench for pot_oversample_ema_hysteresis: windowed averaging, EMA and hysteresis.
// Depends on poeh_pkg and the block's RTL; drives random traffic and predicts every result.
module pot_oversample_ema_hysteresis_tb import poeh_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_BEYOND = 4'd15;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD = 400;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  pot_oversample_ema_hysteresis dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state and its copy of the registers.
  logic [CNT_W-1:0]    cfg_window = OVERSAMPLE_RST;
  logic [ALPHA_W-1:0]  cfg_alpha  = ALPHA_RST;
  logic [SAMPLE_W-1:0] cfg_base   = HYST_BASE_RST;
  logic [GAIN_W-1:0]   cfg_gain   = HYST_GAIN_RST;

  logic [SUM_W-1:0]    win_sum  [NUM_POTS_DEF] = '{default: '0};
  logic [CNT_W-1:0]    win_cnt  [NUM_POTS_DEF] = '{default: '0};
  logic [SAMPLE_W-1:0] ema_val  [NUM_POTS_DEF] = '{default: '0};
  logic [SAMPLE_W-1:0] held_val [NUM_POTS_DEF] = '{default: '0};

  in_item_t  sample_queue[$];
  out_item_t expected_results[$];

  int unsigned mismatches = 0;
  bit          idle_on = 1'b1;
  bit          hold_phase = 1'b0;
  bit          in_xfer = 1'b0;

  // Accumulates one sample; returns 1 with the window's result when it completes.
  function automatic bit filter_window(input in_item_t item, output out_item_t res);
    int          pot;
    int unsigned n, avg, mag;
    longint      prod, level, margin;
    res = '0;
    case (item.adc_channel)
      CHAN_POT0: pot = 0;
      CHAN_POT1: pot = 1;
      CHAN_POT2: pot = 2;
      CHAN_POT3: pot = 3;
      CHAN_POT4: pot = 4;
      default:   pot = -1;
    endcase
    if (pot < 0 || pot >= NUM_POTS_DEF) return 1'b0;
    win_sum[pot] = win_sum[pot] + item.sample;
    win_cnt[pot] = win_cnt[pot] + 1'b1;
    n = cfg_window;
    if (n == 0) n = 1;
    if (n > MAX_WINDOW) n = MAX_WINDOW;
    if (win_cnt[pot] < n) return 1'b0;

    avg = win_sum[pot] / win_cnt[pot];
    if (avg > ADC_MAX) avg = ADC_MAX;
    win_sum[pot] = '0;
    win_cnt[pot] = '0;

    // A flooring shift of the signed product rounds negative steps downward.
    prod  = (longint'(avg) - longint'(ema_val[pot])) * longint'(cfg_alpha);
    level = longint'(ema_val[pot]) + (prod >>> 16);
    if (level < 0) level = 0;
    if (level > ADC_MAX) level = ADC_MAX;
    ema_val[pot] = level[SAMPLE_W-1:0];

    mag = (ema_val[pot] > held_val[pot]) ? ema_val[pot] - held_val[pot]
                                          : held_val[pot] - ema_val[pot];
    margin = longint'(cfg_base) + ((longint'(mag) * longint'(cfg_gain)) >> 16);
    res.stable_changed = 1'b0;
    if (longint'(mag) > margin) begin
      held_val[pot] = ema_val[pot];
      res.stable_changed = 1'b1;
    end
    res.pot_index = POT_W'(pot);
    res.filtered  = ema_val[pot];
    res.stable    = held_val[pot];
    return 1'b1;
  endfunction

  // Monitor: inputs and outputs are sampled at the rising edge.
  always @(posedge clk_i) begin
    out_item_t exp_res;
    out_item_t new_res;
    in_xfer = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result pot=%0d filtered=%0d stable=%0d changed=%0b", $time,
                 out_data_o.pot_index, out_data_o.filtered, out_data_o.stable,
                 out_data_o.stable_changed);
        mismatches++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data_o.pot_index !== exp_res.pot_index ||
            out_data_o.filtered !== exp_res.filtered ||
            out_data_o.stable !== exp_res.stable ||
            out_data_o.stable_changed !== exp_res.stable_changed) begin
          $display("%0t: mismatch expected pot=%0d filtered=%0d stable=%0d changed=%0b",
                   $time, exp_res.pot_index, exp_res.filtered, exp_res.stable,
                   exp_res.stable_changed);
          $display("%0t:          actual   pot=%0d filtered=%0d stable=%0d changed=%0b",
                   $time, out_data_o.pot_index, out_data_o.filtered, out_data_o.stable,
                   out_data_o.stable_changed);
          mismatches++;
        end
      end
    end
    if (in_xfer && filter_window(in_data_i, new_res)) expected_results.push_back(new_res);
  end

  // Sample driver: holds each item until its transfer, with random gaps between items.
  int unsigned in_gap = 0;
  always @(negedge clk_i) begin
    if (!(in_valid_i && !in_xfer)) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (sample_queue.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= sample_queue.pop_front();
        if (idle_on && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 9);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stall bursts, plus one long hold-off that backs up the block.
  int unsigned ready_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (hold_phase && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (ready_gap > 0) begin
      out_ready_i <= 1'b0;
      ready_gap--;
    end else begin
      out_ready_i <= 1'b1;
      if (idle_on && $urandom_range(0, 4) == 0) ready_gap = $urandom_range(1, 9);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_OVERSAMPLE: cfg_window = val[CNT_W-1:0];
      REG_EMA_ALPHA:  cfg_alpha  = val[ALPHA_W-1:0];
      REG_HYST_BASE:  cfg_base   = val[SAMPLE_W-1:0];
      REG_HYST_GAIN:  cfg_gain   = val[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Unused upper data bits are filled at random; the registers keep only their width.
  task automatic configure(input logic [CNT_W-1:0] window, input logic [ALPHA_W-1:0] alpha,
                           input logic [SAMPLE_W-1:0] base, input logic [GAIN_W-1:0] gain);
    write_reg(REG_OVERSAMPLE, {9'($urandom), window});
    write_reg(REG_EMA_ALPHA, alpha);
    write_reg(REG_HYST_BASE, {4'($urandom), base});
    write_reg(REG_HYST_GAIN, gain);
  endtask

  task automatic queue_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] v);
    in_item_t it;
    it.adc_channel = ch;
    it.sample      = v;
    sample_queue.push_back(it);
  endtask

  // Waits until every sample is in and every result is out, then lets the back settle.
  task automatic drain();
    while (sample_queue.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_item_t random_sample(input int unsigned focus_pct,
                                             input logic [CHAN_W-1:0] focus_ch,
                                             input int unsigned level);
    in_item_t    it;
    int unsigned pick, v;
    pick = $urandom_range(0, 99);
    if (pick < focus_pct) begin
      it.adc_channel = focus_ch;
    end else if (pick < 85) begin
      case ($urandom_range(0, 4))
        0:       it.adc_channel = CHAN_POT0;
        1:       it.adc_channel = CHAN_POT1;
        2:       it.adc_channel = CHAN_POT2;
        3:       it.adc_channel = CHAN_POT3;
        default: it.adc_channel = CHAN_POT4;
      endcase
    end else begin
      it.adc_channel = CHAN_W'($urandom_range(0, 15));
    end
    // Small noise around a level in three of eight picks, so the deadband both holds and releases.
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = ADC_MAX;
      2, 3, 4: v = $urandom_range(0, ADC_MAX);
      default: begin
        v = level + $urandom_range(0, 32);
        v = (v < 16) ? 0 : v - 16;
        if (v > ADC_MAX) v = ADC_MAX;
      end
    endcase
    it.sample = SAMPLE_W'(v);
    return it;
  endfunction

  task automatic run_phase(input int unsigned count, input int unsigned focus_pct,
                           input logic [CHAN_W-1:0] focus_ch, input bit with_hold);
    int unsigned level;
    level = $urandom_range(0, ADC_MAX);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 20 == 19) level = $urandom_range(0, ADC_MAX);
      sample_queue.push_back(random_sample(focus_pct, focus_ch, level));
    end
    if (with_hold) hold_phase = 1'b1;
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: unmapped channels are dropped, then one full window of full scale.
    queue_sample(4'd2, ADC_MAX);
    queue_sample(4'd6, '0);
    queue_sample(4'd15, ADC_MAX);
    repeat (8) queue_sample(CHAN_POT0, ADC_MAX);
    drain();

    // A window of zero acts as one; full alpha with no deadband tracks every step.
    write_reg(REG_OVERSAMPLE, 16'hff80);
    write_reg(REG_EMA_ALPHA, 16'hffff);
    write_reg(REG_HYST_BASE, 16'h0000);
    write_reg(REG_HYST_GAIN, 16'h0000);
    queue_sample(CHAN_POT1, ADC_MAX);
    queue_sample(CHAN_POT2, '0);
    queue_sample(CHAN_POT3, ADC_MAX);
    queue_sample(CHAN_POT4, 12'd2048);
    queue_sample(CHAN_POT1, '0);
    queue_sample(CHAN_POT4, 12'd2049);
    drain();

    // A write past the last register must change nothing.
    write_reg(REG_BEYOND, 16'h0001);
    configure(7'd1, 16'h0000, ADC_MAX, 16'hffff);
    queue_sample(CHAN_POT0, ADC_MAX);
    queue_sample(CHAN_POT2, ADC_MAX);
    drain();
    configure(7'd1, 16'hffff, ADC_MAX, 16'hffff);
    queue_sample(CHAN_POT2, ADC_MAX);
    queue_sample(CHAN_POT0, '0);
    drain();

    configure(7'd1, 16'($urandom), 12'($urandom_range(0, 64)), 16'($urandom));
    run_phase(70, 0, CHAN_POT0, 1'b0);

    // Oversize window saturates at the maximum; keep most samples on one pot.
    configure(7'd127, 16'($urandom), 12'($urandom_range(0, 32)), 16'($urandom));
    run_phase(80, 90, CHAN_POT2, 1'b0);

    configure(7'd1, 16'd49152, 12'd4, 16'd6554);
    run_phase(60, 0, CHAN_POT0, 1'b1);

    configure(7'($urandom_range(2, 6)),
              ($urandom_range(0, 1) != 0) ? 16'hffff : 16'($urandom),
              12'($urandom_range(0, 100)), 16'($urandom));
    run_phase(90, 0, CHAN_POT0, 1'b0);

    idle_on = 1'b0;
    configure(7'd2, ALPHA_RST, HYST_BASE_RST, HYST_GAIN_RST);
    run_phase(80, 0, CHAN_POT0, 1'b0);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("pot_oversample_ema_hysteresis verification clean");
    end else begin
      $display("pot_oversample_ema_hysteresis verification failed");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("pot_oversample_ema_hysteresis verification failed");
    $finish;
  end

endmodule
